FILE: hw/rtl/lswc_pkg.sv
package lswc_pkg;

  // outcode bits
  localparam logic [3:0] CODE_INSIDE = 4'b0000;
  localparam logic [3:0] CODE_LEFT   = 4'b0001;
  localparam logic [3:0] CODE_RIGHT  = 4'b0010;
  localparam logic [3:0] CODE_BOTTOM = 4'b0100;
  localparam logic [3:0] CODE_TOP    = 4'b1000;

  // clip rounds before a segment is given up
  localparam int MAX_ROUNDS = 4;

  // serial arithmetic: multiplier digit and divider bits per cycle
  localparam int MUL_DIGIT_BITS = 4;
  localparam int DIV_STEP_BITS  = 2;

  // register indexes
  localparam logic [1:0] REG_WINDOW_LEFT   = 2'd0;
  localparam logic [1:0] REG_WINDOW_RIGHT  = 2'd1;
  localparam logic [1:0] REG_WINDOW_BOTTOM = 2'd2;
  localparam logic [1:0] REG_WINDOW_TOP    = 2'd3;

  typedef struct packed {
    logic load_in;
    logic setup;
    logic mul_step;
    logic div_step;
    logic update;
    logic out_load;
    logic out_accept;
  } lswc_cmd_t;

  typedef struct packed {
    logic all_inside;
    logic share_out;
  } lswc_stat_t;

endpackage

FILE: hw/rtl/lswc_datapath.sv
module lswc_datapath #(
  parameter int COORD_INT_BITS  = 16,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                                                clk,
  input  lswc_pkg::lswc_cmd_t                                 cmd,
  output lswc_pkg::lswc_stat_t                                stat,
  input  logic signed [15:0]                                  window_left,
  input  logic signed [15:0]                                  window_right,
  input  logic signed [15:0]                                  window_bottom,
  input  logic signed [15:0]                                  window_top,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]    in_start_x,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]    in_start_y,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]    in_end_x,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]    in_end_y,
  output logic                                                out_accepted,
  output logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]    out_clipped_start_x,
  output logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]    out_clipped_start_y,
  output logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]    out_clipped_end_x,
  output logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]    out_clipped_end_y
);
  import lswc_pkg::*;

  localparam int W      = COORD_INT_BITS + COORD_FRAC_BITS;
  localparam int QW     = 2 * W;
  localparam int MS     = (W + MUL_DIGIT_BITS - 1) / MUL_DIGIT_BITS;
  localparam int BPW    = MS * MUL_DIGIT_BITS;
  localparam int CLW    = (QW > 63) ? QW : 63;
  localparam int SW     = CLW + 2;
  localparam int EBW    = (((16 + COORD_FRAC_BITS) > W) ? (16 + COORD_FRAC_BITS) : W) + 1;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [CLW-1:0] QLIM = CLW'(64'h4000_0000_0000_0000);

  // integer window edge scaled to the coordinate format, saturated
  function automatic logic signed [W-1:0] edge_val(input logic signed [15:0] e);
    logic signed [EBW-1:0] v;
    v = EBW'(e) <<< COORD_FRAC_BITS;
    if (v > EBW'(CMAX)) return CMAX;
    if (v < EBW'(CMIN)) return CMIN;
    return W'(v);
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W:0] v);
    logic signed [W:0] n;
    n = -v;
    return v[W] ? n[W-1:0] : v[W-1:0];
  endfunction

  logic signed [W-1:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [W-1:0] xl, xr, yb, yt;
  logic [3:0]          c1, c2, co;
  logic                first, vert;
  logic signed [W-1:0] e_sel;
  logic signed [W:0]   dx, dy, bsub, a_s, d_s;

  logic [W-1:0]        a_mag_r, d_mag_r, rem_r, rem_nxt;
  logic [BPW-1:0]      b_sh_r;
  logic [QW-1:0]       pq_r, pq_nxt, div_pq;
  logic                neg_r, vert_r, first_r;
  logic signed [W-1:0] e_r;
  logic [W+MUL_DIGIT_BITS-1:0] pp;

  logic [CLW-1:0]      qz;
  logic signed [SW-1:0] sq, sum;
  logic signed [W-1:0] base, newc;

  logic                out_accepted_r;
  logic signed [W-1:0] out_sx_r, out_sy_r, out_ex_r, out_ey_r;

  assign xl = edge_val(window_left);
  assign xr = edge_val(window_right);
  assign yb = edge_val(window_bottom);
  assign yt = edge_val(window_top);

  // outcodes of the current endpoints
  always_comb begin
    c1 = CODE_INSIDE;
    if (x1_r < xl) c1 = c1 | CODE_LEFT;
    else if (x1_r > xr) c1 = c1 | CODE_RIGHT;
    if (y1_r < yb) c1 = c1 | CODE_BOTTOM;
    else if (y1_r > yt) c1 = c1 | CODE_TOP;
    c2 = CODE_INSIDE;
    if (x2_r < xl) c2 = c2 | CODE_LEFT;
    else if (x2_r > xr) c2 = c2 | CODE_RIGHT;
    if (y2_r < yb) c2 = c2 | CODE_BOTTOM;
    else if (y2_r > yt) c2 = c2 | CODE_TOP;
  end

  assign stat.all_inside = (c1 == CODE_INSIDE) && (c2 == CODE_INSIDE);
  assign stat.share_out  = (c1 & c2) != CODE_INSIDE;

  // operand selection for one clip round
  always_comb begin
    first = (c1 != CODE_INSIDE);
    co    = first ? c1 : c2;
    vert  = ((co & CODE_TOP) != CODE_INSIDE) || ((co & CODE_BOTTOM) != CODE_INSIDE);
    if ((co & CODE_TOP) != CODE_INSIDE) e_sel = yt;
    else if ((co & CODE_BOTTOM) != CODE_INSIDE) e_sel = yb;
    else if ((co & CODE_RIGHT) != CODE_INSIDE) e_sel = xr;
    else e_sel = xl;
    dx   = (W+1)'(x2_r) - (W+1)'(x1_r);
    dy   = (W+1)'(y2_r) - (W+1)'(y1_r);
    bsub = (W+1)'(e_sel) - (W+1)'(vert ? y1_r : x1_r);
    a_s  = vert ? dx : dy;
    d_s  = vert ? dy : dx;
  end

  // radix-16 multiply step, msb digit first
  always_comb begin
    pp     = (W+MUL_DIGIT_BITS)'(a_mag_r) *
             (W+MUL_DIGIT_BITS)'(b_sh_r[BPW-1 -: MUL_DIGIT_BITS]);
    pq_nxt = (pq_r << MUL_DIGIT_BITS) + QW'(pp);
  end

  // restoring divide, dividend shifts out the top while quotient fills the bottom
  always_comb begin
    logic [W:0] t;
    rem_nxt = rem_r;
    div_pq  = pq_r;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      t      = {rem_nxt, div_pq[QW-1]};
      div_pq = div_pq << 1;
      if (t >= {1'b0, d_mag_r}) begin
        t         = t - {1'b0, d_mag_r};
        div_pq[0] = 1'b1;
      end
      rem_nxt = t[W-1:0];
    end
  end

  // new coordinate from the quotient
  always_comb begin
    qz = (d_mag_r == '0) ? '0 : CLW'(pq_r);
    if (qz > QLIM) qz = QLIM;
    sq   = neg_r ? -$signed(SW'(qz)) : $signed(SW'(qz));
    base = vert_r ? x1_r : y1_r;
    sum  = SW'(base) + sq;
    if (sum > SW'(CMAX)) newc = CMAX;
    else if (sum < SW'(CMIN)) newc = CMIN;
    else newc = W'(sum);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x1_r <= in_start_x;
      y1_r <= in_start_y;
      x2_r <= in_end_x;
      y2_r <= in_end_y;
    end else if (cmd.update) begin
      if (first_r) begin
        x1_r <= vert_r ? newc : e_r;
        y1_r <= vert_r ? e_r : newc;
      end else begin
        x2_r <= vert_r ? newc : e_r;
        y2_r <= vert_r ? e_r : newc;
      end
    end

    if (cmd.setup) begin
      a_mag_r <= mag(a_s);
      b_sh_r  <= BPW'(mag(bsub));
      d_mag_r <= mag(d_s);
      neg_r   <= a_s[W] ^ bsub[W] ^ d_s[W];
      e_r     <= e_sel;
      vert_r  <= vert;
      first_r <= first;
      pq_r    <= '0;
      rem_r   <= '0;
    end else if (cmd.mul_step) begin
      pq_r   <= pq_nxt;
      b_sh_r <= b_sh_r << MUL_DIGIT_BITS;
    end else if (cmd.div_step) begin
      pq_r  <= div_pq;
      rem_r <= rem_nxt;
    end

    if (cmd.out_load) begin
      out_accepted_r <= cmd.out_accept;
      out_sx_r       <= cmd.out_accept ? x1_r : '0;
      out_sy_r       <= cmd.out_accept ? y1_r : '0;
      out_ex_r       <= cmd.out_accept ? x2_r : '0;
      out_ey_r       <= cmd.out_accept ? y2_r : '0;
    end
  end

  assign out_accepted        = out_accepted_r;
  assign out_clipped_start_x = out_sx_r;
  assign out_clipped_start_y = out_sy_r;
  assign out_clipped_end_x   = out_ex_r;
  assign out_clipped_end_y   = out_ey_r;

endmodule

FILE: hw/rtl/lswc_ctrl.sv
module lswc_ctrl #(
  parameter int COORD_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  lswc_pkg::lswc_stat_t stat,
  output lswc_pkg::lswc_cmd_t  cmd
);
  import lswc_pkg::*;

  localparam int MS = (COORD_BITS + MUL_DIGIT_BITS - 1) / MUL_DIGIT_BITS;
  localparam int DS = (2 * COORD_BITS) / DIV_STEP_BITS;
  localparam int CN = (MS > DS) ? MS : DS;
  localparam int CW = $clog2(CN);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [2:0]    round_r, round_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_free, finish;

  assign out_free = !out_valid_r || out_ready;
  assign finish   = stat.all_inside || stat.share_out || (round_r == 3'(MAX_ROUNDS));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    round_nxt = round_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          round_nxt   = '0;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (finish) begin
          if (out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_accept = stat.all_inside;
            state_nxt      = S_IDLE;
          end
        end else begin
          cmd.setup = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt_r == CW'(MS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CW'(DS - 1)) begin
          state_nxt = S_UPD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        round_nxt  = round_r + 1'b1;
        state_nxt  = S_EVAL;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten while still pending");

  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EVAL))
    else $error("accepted request did not start evaluation");

  a_round_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && round_r == 3'(MAX_ROUNDS)) |-> !cmd.setup)
    else $error("clip round started past the limit");

  a_update_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> (state_r == S_EVAL && round_r != 3'd0))
    else $error("update not followed by outcode check");

endmodule

FILE: hw/rtl/line_segment_window_clipper_unit.sv
// cohen-sutherland line clipper against a rectangular window
// input channel: in_valid/in_ready carry one segment per request, two endpoints
//   in signed fixed point (COORD_INT_BITS.COORD_FRAC_BITS, q16.8 by default)
// output channel: out_valid/out_ready carry one result per request: accepted flag
//   plus the clipped endpoints, all zero when the segment is rejected
// window: four signed integer edge registers on an apb-style port at byte
//   addresses 0, 4, 8, 12 (left, right, bottom, top); the user must see that they
//   are written only while idle, the block itself does not enforce it
// timing: segments are handled one at a time; a segment needs n clip rounds
//   (n from 0 to 4), each an outcode check with operand setup, the serial
//   multiply, the serial divide and an endpoint update
// each round is bounded by the serial multiplier (4 bits of the multiplier per
//   cycle) and the restoring divider (2 quotient bits per cycle)
// the next request can be taken in the cycle after a result is loaded, while that
//   result may still sit in the output register
// a stalled receiver holds the result in the output register; a second result
//   waits in the endpoint registers of the datapath until the first one is taken
// reset: synchronous, active low; clears the controller, the output valid and
//   the window registers (all edges zero)
module line_segment_window_clipper_unit #(
  parameter int COORD_INT_BITS  = 16,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  // segment requests
  input  logic                                             in_valid,
  output logic                                             in_ready,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_start_x,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_start_y,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_end_x,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_end_y,
  // clip results
  output logic                                             out_valid,
  input  logic                                             out_ready,
  output logic                                             out_accepted,
  output logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] out_clipped_start_x,
  output logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] out_clipped_start_y,
  output logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] out_clipped_end_x,
  output logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] out_clipped_end_y,
  // window registers
  input  logic                                             psel,
  input  logic                                             penable,
  input  logic                                             pwrite,
  input  logic [3:0]                                       paddr,
  input  logic [31:0]                                      pwdata,
  output logic [31:0]                                      prdata,
  output logic                                             pready
);
  import lswc_pkg::*;

  localparam int W = COORD_INT_BITS + COORD_FRAC_BITS;

  logic signed [15:0] window_left_r, window_right_r, window_bottom_r, window_top_r;
  logic               reg_wr;
  logic [1:0]         reg_idx;
  logic [15:0]        rd_val;
  lswc_cmd_t          cmd;
  lswc_stat_t         stat;

  // apb: no wait states, write lands in the access phase
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_left_r   <= '0;
      window_right_r  <= '0;
      window_bottom_r <= '0;
      window_top_r    <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_WINDOW_LEFT:   window_left_r   <= pwdata[15:0];
        REG_WINDOW_RIGHT:  window_right_r  <= pwdata[15:0];
        REG_WINDOW_BOTTOM: window_bottom_r <= pwdata[15:0];
        REG_WINDOW_TOP:    window_top_r    <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // read back, sign extended to the bus
  always_comb begin
    case (reg_idx)
      REG_WINDOW_LEFT:   rd_val = window_left_r;
      REG_WINDOW_RIGHT:  rd_val = window_right_r;
      REG_WINDOW_BOTTOM: rd_val = window_bottom_r;
      REG_WINDOW_TOP:    rd_val = window_top_r;
      default:           rd_val = '0;
    endcase
  end
  assign prdata = {{16{rd_val[15]}}, rd_val};

  // sequencer: outcode check, multiply, divide, endpoint update per round
  lswc_ctrl #(
    .COORD_BITS(W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // endpoint registers, outcodes, serial mul/div and the output register
  lswc_datapath #(
    .COORD_INT_BITS (COORD_INT_BITS),
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_datapath (
    .clk                (clk),
    .cmd                (cmd),
    .stat               (stat),
    .window_left        (window_left_r),
    .window_right       (window_right_r),
    .window_bottom      (window_bottom_r),
    .window_top         (window_top_r),
    .in_start_x         (in_start_x),
    .in_start_y         (in_start_y),
    .in_end_x           (in_end_x),
    .in_end_y           (in_end_y),
    .out_accepted       (out_accepted),
    .out_clipped_start_x(out_clipped_start_x),
    .out_clipped_start_y(out_clipped_start_y),
    .out_clipped_end_x  (out_clipped_end_x),
    .out_clipped_end_y  (out_clipped_end_y)
  );

endmodule

FILE: tb/tb_line_segment_window_clipper_unit.sv
`timescale 1ns / 1ps
module tb_line_segment_window_clipper_unit;
  import lswc_pkg::*;

  // coordinate format of the block: signed q16.8
  localparam int INT_BITS  = 16;
  localparam int FRAC_BITS = 8;
  localparam int CW        = INT_BITS + FRAC_BITS;

  localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  // quotient clamp of the intersection arithmetic
  localparam longint QUOT_CAP  = longint'(1) << 62;

  localparam int NUM_WINDOW_REGS = 4;
  localparam int IDLE_PCT        = 18;
  localparam int ITEMS_PER_PHASE = 86;
  localparam int RANDOM_PHASES   = 7;
  // run limit far beyond what even a slow pass needs
  localparam int CYCLE_LIMIT     = 1000000;
  // longest clip latency plus margin
  localparam int SETTLE_CYCLES   = 150;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [15:0]   edge_t;

  typedef struct packed {
    logic   accepted;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } clip_result_t;

  // all inputs known from time zero
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  coord_t      in_start_x = '0;
  coord_t      in_start_y = '0;
  coord_t      in_end_x   = '0;
  coord_t      in_end_y   = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic        out_accepted;
  coord_t      out_clipped_start_x;
  coord_t      out_clipped_start_y;
  coord_t      out_clipped_end_x;
  coord_t      out_clipped_end_y;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [3:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;

  // window edges as the predictor sees them, reset value zero
  edge_t        window_edge [NUM_WINDOW_REGS] = '{default: '0};
  // expected clip results, oldest first
  clip_result_t pending_clips [$];

  // when set, neither side inserts idle cycles
  bit steady_flow     = 1'b0;
  int fail_count      = 0;
  int segments_sent   = 0;
  int results_seen    = 0;
  int accepted_seen   = 0;
  int window_settings = 0;
  int cycle_count     = 0;

  line_segment_window_clipper_unit #(
    .COORD_INT_BITS (INT_BITS),
    .COORD_FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_start_x         (in_start_x),
    .in_start_y         (in_start_y),
    .in_end_x           (in_end_x),
    .in_end_y           (in_end_y),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accepted       (out_accepted),
    .out_clipped_start_x(out_clipped_start_x),
    .out_clipped_start_y(out_clipped_start_y),
    .out_clipped_end_x  (out_clipped_end_x),
    .out_clipped_end_y  (out_clipped_end_y),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // integer edge moved onto the fixed point grid
  function automatic longint edge_position(edge_t e);
    return clamp_coord(longint'(e) * (longint'(1) << FRAC_BITS));
  endfunction

  // trunc(num_a * num_b / den) toward zero; the product never exceeds 50 bits here
  function automatic longint scaled_ratio(longint num_a, longint num_b, longint den);
    longint unsigned mag_a, mag_b, mag_d, quot;
    logic            negative;
    if (den == 0) return 0;
    mag_a = (num_a < 0) ? -num_a : num_a;
    mag_b = (num_b < 0) ? -num_b : num_b;
    mag_d = (den < 0) ? -den : den;
    quot  = (mag_a * mag_b) / mag_d;
    if (quot > QUOT_CAP) quot = QUOT_CAP;
    negative = ((num_a < 0) != (num_b < 0)) != (den < 0);
    return negative ? -longint'(quot) : longint'(quot);
  endfunction

  function automatic logic [3:0] region_code(input longint x, y, xl, xr, yb, yt);
    logic [3:0] code;
    code = CODE_INSIDE;
    if (x < xl) code |= CODE_LEFT;
    else if (x > xr) code |= CODE_RIGHT;
    if (y < yb) code |= CODE_BOTTOM;
    else if (y > yt) code |= CODE_TOP;
    return code;
  endfunction

  // cohen-sutherland against the current window copy
  function automatic clip_result_t clip_segment(input coord_t sx, sy, ex, ey);
    longint       x1, y1, x2, y2, xl, xr, yb, yt, nx, ny;
    logic [3:0]   c1, c2, moving;
    logic         move_first;
    clip_result_t res;
    x1  = sx;
    y1  = sy;
    x2  = ex;
    y2  = ey;
    xl  = edge_position(window_edge[REG_WINDOW_LEFT]);
    xr  = edge_position(window_edge[REG_WINDOW_RIGHT]);
    yb  = edge_position(window_edge[REG_WINDOW_BOTTOM]);
    yt  = edge_position(window_edge[REG_WINDOW_TOP]);
    c1  = region_code(x1, y1, xl, xr, yb, yt);
    c2  = region_code(x2, y2, xl, xr, yb, yt);
    res = '0;
    for (int pass_no = 0; pass_no <= MAX_ROUNDS; pass_no++) begin
      if (c1 == CODE_INSIDE && c2 == CODE_INSIDE) begin
        res.accepted = 1'b1;
        res.start_x  = coord_t'(x1);
        res.start_y  = coord_t'(y1);
        res.end_x    = coord_t'(x2);
        res.end_y    = coord_t'(y2);
        break;
      end
      // shared outside bit or out of rounds: rejected, all zero
      if ((c1 & c2) != CODE_INSIDE) break;
      if (pass_no == MAX_ROUNDS) break;
      move_first = (c1 != CODE_INSIDE);
      moving     = move_first ? c1 : c2;
      if ((moving & CODE_TOP) != CODE_INSIDE) begin
        nx = x1 + scaled_ratio(x2 - x1, yt - y1, y2 - y1);
        ny = yt;
      end else if ((moving & CODE_BOTTOM) != CODE_INSIDE) begin
        nx = x1 + scaled_ratio(x2 - x1, yb - y1, y2 - y1);
        ny = yb;
      end else if ((moving & CODE_RIGHT) != CODE_INSIDE) begin
        ny = y1 + scaled_ratio(y2 - y1, xr - x1, x2 - x1);
        nx = xr;
      end else begin
        ny = y1 + scaled_ratio(y2 - y1, xl - x1, x2 - x1);
        nx = xl;
      end
      nx = clamp_coord(nx);
      ny = clamp_coord(ny);
      if (move_first) begin
        x1 = nx;
        y1 = ny;
        c1 = region_code(x1, y1, xl, xr, yb, yt);
      end else begin
        x2 = nx;
        y2 = ny;
        c2 = region_code(x2, y2, xl, xr, yb, yt);
      end
    end
    return res;
  endfunction

  // a coordinate around one axis of the window, now and then exactly on an edge
  function automatic coord_t axis_coord(edge_t edge_a, edge_t edge_b);
    longint lo, hi, span, reach;
    lo    = (edge_a < edge_b) ? edge_a : edge_b;
    hi    = (edge_a < edge_b) ? edge_b : edge_a;
    span  = hi - lo + 4;
    reach = (hi - lo + 2 * span) * (longint'(1) << FRAC_BITS) + 255;
    if ($urandom_range(0, 9) == 0)
      return coord_t'(edge_position($urandom_range(0, 1) ? edge_a : edge_b));
    return coord_t'(clamp_coord((lo - span) * (longint'(1) << FRAC_BITS)
                                + longint'($urandom_range(0, int'(reach)))));
  endfunction

  // ---------------------------------------------------------------- drivers

  // one segment request; valid stays up after acceptance unless the next
  // call idles or the caller drains, so valid never drops and rises in one step
  task automatic send_segment(input longint sx, sy, ex, ey);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= coord_t'(sx);
    in_start_y <= coord_t'(sy);
    in_end_x   <= coord_t'(ex);
    in_end_y   <= coord_t'(ey);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_clips.push_back(clip_segment(coord_t'(sx), coord_t'(sy),
                                         coord_t'(ex), coord_t'(ey)));
    segments_sent++;
  endtask

  // sender holds off until every outstanding result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_clips.size() != 0) @(posedge clk);
  endtask

  // writes each edge register, then reads each back; only called while idle
  task automatic program_window(input int left_e, right_e, bottom_e, top_e);
    edge_t      values [NUM_WINDOW_REGS];
    logic [1:0] index;
    values[REG_WINDOW_LEFT]   = edge_t'(left_e);
    values[REG_WINDOW_RIGHT]  = edge_t'(right_e);
    values[REG_WINDOW_BOTTOM] = edge_t'(bottom_e);
    values[REG_WINDOW_TOP]    = edge_t'(top_e);
    for (int step = 0; step < 2 * NUM_WINDOW_REGS; step++) begin
      index = step[1:0];
      // setup phase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (step < NUM_WINDOW_REGS);
      paddr   <= {index, 2'b00};
      pwdata  <= {{16{values[index][15]}}, values[index]};
      @(posedge clk);
      // access phase
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if (step >= NUM_WINDOW_REGS && prdata[15:0] !== values[index]) begin
        $error("window register %0d readback: expected %0d, got %0d",
               index, values[index], $signed(prdata[15:0]));
        fail_count++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    window_edge = values;
    window_settings++;
  endtask

  // ---------------------------------------------------------------- result side

  task automatic compare_field(input string label, input logic signed [CW-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", label, want, got);
      fail_count++;
    end
  endtask

  // each result handshake is checked against the oldest expectation,
  // then the receiver decides whether to stall the next cycle
  always @(posedge clk) begin : result_check
    clip_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_clips.size() == 0) begin
        $error("result request with no segment outstanding (accepted=%0b)", out_accepted);
        fail_count++;
      end else begin
        want = pending_clips.pop_front();
        accepted_seen += want.accepted;
        compare_field("accepted",        want.accepted, out_accepted);
        compare_field("clipped_start_x", want.start_x,  out_clipped_start_x);
        compare_field("clipped_start_y", want.start_y,  out_clipped_start_y);
        compare_field("clipped_end_x",   want.end_x,    out_clipped_end_x);
        compare_field("clipped_end_y",   want.end_y,    out_clipped_end_y);
      end
    end
    out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // window left at reset: a single point at the origin
  task automatic test_reset_window();
    send_segment(-256, -256, 256, 256);
    send_segment(0, 0, 0, 0);
    send_segment(1, 0, 1, 0);
    wait_for_results();
  endtask

  // register extremes and alternating bit patterns, each read back
  task automatic test_window_registers();
    program_window(-32768, 32767, -32768, 32767);
    // largest coordinates lie just past the right and top edges
    send_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_segment(0, 0, COORD_MAX, 0);
    wait_for_results();
    program_window(-21846, 21845, -21846, 21845);
    send_segment(-1, -1, 1, 1);
    wait_for_results();
  endtask

  // fully inside, and both endpoints beyond each single edge
  task automatic test_trivial_cases();
    program_window(-10, 10, -5, 5);
    send_segment(-512, 300, 1000, -700);
    send_segment(-5000, 0, -3000, 100);
    send_segment(3000, -100, 6000, 200);
    send_segment(0, -2000, 500, -1500);
    send_segment(-100, 2000, 100, 9000);
    wait_for_results();
  endtask

  // clips against each edge, on either endpoint, plus a corner miss
  task automatic test_edge_clipping();
    send_segment(-5000, 256, 5000, 256);
    send_segment(128, -4000, 128, 4000);
    send_segment(0, 0, 1000, 5000);
    send_segment(-6000, -300, 100, 200);
    // only the second endpoint is outside
    send_segment(200, 100, 4000, -3000);
    // codes share no bit but the line passes outside the corner
    send_segment(2048, -5120, 7680, 512);
    // fractional endpoints, truncation of the quotient
    send_segment(-3001, 77, 4001, -1999);
    send_segment(-4000, 3000, 3999, -2999);
    wait_for_results();
  endtask

  task automatic test_coordinate_extremes();
    send_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    send_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_segment(COORD_MIN, 0, COORD_MAX, 0);
    wait_for_results();
  endtask

  // left > right and bottom > top: every point is outside, so every segment is rejected
  task automatic test_inverted_window();
    program_window(10, -10, 5, -5);
    send_segment(0, 0, 0, 0);
    send_segment(-5000, -5000, 5000, 5000);
    send_segment(5000, -5000, -5000, 5000);
    send_segment(-256, -256, 256, 256);
    wait_for_results();
  endtask

  // phases of random segments, each under its own window
  task automatic test_random_traffic();
    coord_t pt [4];
    int     mode;
    int     base_x, base_y;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // first phase runs with no idling on either side
      steady_flow = (phase == 0);
      case (phase)
        0: program_window(-100, 150, -80, 60);
        1: program_window(-32768, 32767, -32768, 32767);
        2: program_window(7, 7, -3, -3);
        3: program_window(32000, 32767, -32768, -32000);
        4: program_window(50, -50, 30, -30);
        5: begin
          base_x = int'($urandom_range(0, 4000)) - 2000;
          base_y = int'($urandom_range(0, 4000)) - 2000;
          program_window(base_x, base_x + int'($urandom_range(0, 300)),
                         base_y, base_y + int'($urandom_range(0, 300)));
        end
        default: begin
          program_window(-int'($urandom_range(0, 32768)), int'($urandom_range(0, 32767)),
                         -int'($urandom_range(0, 32768)), int'($urandom_range(0, 32767)));
        end
      endcase
      for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
        // full-range noise by default
        for (int k = 0; k < 4; k++) pt[k] = coord_t'($urandom);
        mode = $urandom_range(0, 99);
        if (mode < 75) begin
          pt[0] = axis_coord(window_edge[REG_WINDOW_LEFT], window_edge[REG_WINDOW_RIGHT]);
          pt[1] = axis_coord(window_edge[REG_WINDOW_BOTTOM], window_edge[REG_WINDOW_TOP]);
        end
        if (mode < 60) begin
          // both endpoints around the window
          pt[2] = axis_coord(window_edge[REG_WINDOW_LEFT], window_edge[REG_WINDOW_RIGHT]);
          pt[3] = axis_coord(window_edge[REG_WINDOW_BOTTOM], window_edge[REG_WINDOW_TOP]);
        end else if (mode < 85 && mode >= 75) begin
          // short segment near the window
          pt[0] = axis_coord(window_edge[REG_WINDOW_LEFT], window_edge[REG_WINDOW_RIGHT]);
          pt[1] = axis_coord(window_edge[REG_WINDOW_BOTTOM], window_edge[REG_WINDOW_TOP]);
          pt[2] = coord_t'(clamp_coord(longint'(pt[0]) + int'($urandom_range(0, 1024)) - 512));
          pt[3] = coord_t'(clamp_coord(longint'(pt[1]) + int'($urandom_range(0, 1024)) - 512));
        end else if (mode < 90 && mode >= 85) begin
          // zero-length segment
          pt[0] = axis_coord(window_edge[REG_WINDOW_LEFT], window_edge[REG_WINDOW_RIGHT]);
          pt[1] = axis_coord(window_edge[REG_WINDOW_BOTTOM], window_edge[REG_WINDOW_TOP]);
          pt[2] = pt[0];
          pt[3] = pt[1];
        end
        send_segment(pt[0], pt[1], pt[2], pt[3]);
        // sender stops mid-phase until the block has emptied
        if (phase == 2 && item == ITEMS_PER_PHASE / 2) wait_for_results();
      end
      wait_for_results();
    end
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_window();
    test_window_registers();
    test_trivial_cases();
    test_edge_clipping();
    test_coordinate_extremes();
    test_inverted_window();
    test_random_traffic();
    // catch any stray result after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("clipped %0d segments, %0d results checked: %0d inside the window, %0d rejected",
             segments_sent, results_seen, accepted_seen, results_seen - accepted_seen);
    $display("%0d window settings, among them full-range, single-point and inverted windows",
             window_settings);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
